[src/hsrm_pkg.sv]
// Shared constants, types and state encoding for the half-set reference mean core.
package hsrm_pkg;

   // Store depth and coordinate width.
   localparam int MAX_POINTS = 64;
   localparam int COORD_BITS = 12;

   // Derived widths.
   localparam int ADDR_W = $clog2(MAX_POINTS);
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int SUM_W  = COORD_BITS + $clog2(MAX_POINTS);
   localparam int STEP_W = $clog2(SUM_W + 1);
   localparam int POINT_W = 2 * COORD_BITS;

   // Reference point codes carried on mode and which_ref.
   localparam logic [1:0] MODE_LEFT   = 2'd0;
   localparam logic [1:0] MODE_RIGHT  = 2'd1;
   localparam logic [1:0] MODE_TOP    = 2'd2;
   localparam logic [1:0] MODE_BOTTOM = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_LOAD,
      ST_LATCH,
      ST_SCAN,
      ST_DECIDE,
      ST_DIV,
      ST_RESULT
   } state_type;

endpackage

[src/hsrm_div.sv]
// Restoring divider that retires one quotient bit per cycle.
module hsrm_div
   import hsrm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] dividend,
   input  logic [CNT_W-1:0] divisor,
   output logic             done,
   output logic [SUM_W-1:0] quotient
);

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  div_ff, div_in;
   logic [CNT_W:0]    rem_shift;
   logic [CNT_W+1:0]  diff;
   logic              ge;
   logic              last_step;

   always_comb begin
      // Bring down the next dividend bit and try a subtraction.
      rem_shift = {rem_ff, quo_ff[SUM_W-1]};
      diff      = {1'b0, rem_shift} - {2'b00, div_ff};
      ge        = ~diff[CNT_W+1];
      last_step = (step_ff == STEP_W'(SUM_W - 1));

      busy_in = busy_ff;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      done    = 1'b0;

      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[SUM_W-2:0], ge};
         rem_in  = ge ? diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
         step_in = step_ff + STEP_W'(1);
         if (last_step) begin
            busy_in = 1'b0;
            done    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   // The final quotient bit is shifted in on the cycle that done is high.
   assign quotient = {quo_ff[SUM_W-2:0], ge};

endmodule

[src/half_set_reference_mean_core.sv]
// Top level of the half-set reference mean core: point store, rank sequencer and result stage.
// Sequence: a sample is written to the store as it is taken, unless the store is full. With n
//   stored points the result follows the closing item through a setup state, then per point a load,
//   a latch, n compares and a decide on the single read port, then the divide; an empty chosen half
//   goes from setup straight to the result. Throughput: one sample per cycle while loading, none from the
//   closing item until its result is taken. Reset: synchronous, active high; empties the store.
module half_set_reference_mean_core
   import hsrm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [COORD_BITS-1:0] req_x_coord,
   input  logic [COORD_BITS-1:0] req_y_coord,
   input  logic [1:0]            req_mode,
   input  logic                  req_last,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [COORD_BITS-1:0] rsp_ref_value,
   output logic [1:0]            rsp_which_ref,
   output logic                  rsp_ok
);

   // The point store holds x in the low half of each entry and y in the high half.
   logic [POINT_W-1:0] point_store_mem [MAX_POINTS];
   logic [POINT_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]  rd_addr;
   logic               wr_en;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]      count_ff, count_in;    // points stored so far
   logic [CNT_W-1:0]      n_ff, n_in;            // size of the set being evaluated
   logic [1:0]            mode_ff, mode_in;
   logic [CNT_W-1:0]      i_ff, i_in;            // point whose rank is being found
   logic [CNT_W-1:0]      j_ff, j_in;            // point whose data sits in rd_data_ff
   logic [CNT_W-1:0]      rank_ff, rank_in;
   logic [COORD_BITS-1:0] key_i_ff, key_i_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [COORD_BITS-1:0] value_ff, value_in;
   logic                  ok_ff, ok_in;

   logic                  req_accept;
   logic                  rsp_accept;
   logic                  store_room;
   logic [CNT_W-1:0]      half;
   logic                  take_lower;
   logic [CNT_W-1:0]      sel_count;
   logic [COORD_BITS-1:0] key_j;
   logic                  j_less;
   logic                  scan_end;
   logic                  set_end;
   logic                  div_start;
   logic                  div_done;
   logic [SUM_W-1:0]      div_quotient;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign store_room = (count_ff < CNT_W'(MAX_POINTS));

   // The lower half holds the floor(n/2) smallest keys, the upper half the rest.
   // Right and top average the lower half; left and bottom average the upper half.
   assign half       = n_ff >> 1;
   assign take_lower = (mode_ff == MODE_RIGHT) || (mode_ff == MODE_TOP);
   assign sel_count  = take_lower ? half : (n_ff - half);

   // Top and bottom sort by y, left and right by x.
   assign key_j = mode_ff[1] ? rd_data_ff[POINT_W-1:COORD_BITS] : rd_data_ff[COORD_BITS-1:0];

   // Rank with ties broken by store position, so every point gets a distinct rank
   // and exactly floor(n/2) points land in the lower half.
   assign j_less   = (key_j < key_i_ff) || ((key_j == key_i_ff) && (j_ff < i_ff));
   assign scan_end = (j_ff == n_ff - CNT_W'(1));
   assign set_end  = (i_ff == n_ff - CNT_W'(1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_last) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            // An empty half skips straight to a failed result.
            state_in = (sel_count == '0) ? ST_RESULT : ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_LATCH;
         end
         ST_LATCH: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_end) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = set_end ? ST_DIV : ST_LOAD;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (rsp_accept) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath controls and next register values.
   always_comb begin
      count_in  = count_ff;
      n_in      = n_ff;
      mode_in   = mode_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      rank_in   = rank_ff;
      key_i_in  = key_i_ff;
      sum_in    = sum_ff;
      value_in  = value_ff;
      ok_in     = ok_ff;
      rd_addr   = i_ff[ADDR_W-1:0];
      wr_en     = 1'b0;
      div_start = 1'b0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_accept) begin
               // Samples past the store depth, the closing one included, are dropped.
               wr_en   = store_room;
               mode_in = req_mode;
               if (store_room) begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_last) begin
                  n_in = store_room ? (count_ff + CNT_W'(1)) : count_ff;
               end
            end
         end
         ST_SETUP: begin
            i_in     = '0;
            sum_in   = '0;
            value_in = '0;
            ok_in    = 1'b0;
         end
         ST_LOAD: begin
            rd_addr = i_ff[ADDR_W-1:0];
         end
         ST_LATCH: begin
            // Point i is in the read register; start the sweep at entry zero.
            key_i_in = key_j;
            rd_addr  = '0;
            j_in     = '0;
            rank_in  = '0;
         end
         ST_SCAN: begin
            rd_addr = ADDR_W'(j_ff + CNT_W'(1));
            j_in    = j_ff + CNT_W'(1);
            if (j_less) begin
               rank_in = rank_ff + CNT_W'(1);
            end
         end
         ST_DECIDE: begin
            if ((rank_ff < half) == take_lower) begin
               sum_in = sum_ff + SUM_W'(key_i_ff);
            end
            i_in      = i_ff + CNT_W'(1);
            div_start = set_end;
         end
         ST_DIV: begin
            if (div_done) begin
               value_in = div_quotient[COORD_BITS-1:0];
               ok_in    = 1'b1;
            end
         end
         ST_RESULT: begin
            rsp_valid = 1'b1;
            if (rsp_accept) begin
               count_in = '0;
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      n_ff     <= n_in;
      mode_ff  <= mode_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      rank_ff  <= rank_in;
      key_i_ff <= key_i_in;
      sum_ff   <= sum_in;
      value_ff <= value_in;
      ok_ff    <= ok_in;
   end

   // Point store with one write port and a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         point_store_mem[count_ff[ADDR_W-1:0]] <= {req_y_coord, req_x_coord};
      end
      rd_data_ff <= point_store_mem[rd_addr];
   end

   // The divisor is the size of the chosen half, nonzero whenever the divider runs.
   hsrm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .divisor  (sel_count),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp_ref_value = value_ff;
   assign rsp_which_ref = mode_ff;
   assign rsp_ok        = ok_ff;

endmodule

[dv/half_set_reference_mean_core_tb.sv]
// Self-checking testbench for the half-set reference mean core with a built-in result predictor.
module half_set_reference_mean_core_tb
   import hsrm_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // The largest coordinate value and the number of quiet cycles that the watchdog tolerates.
   // The limit leaves a wide margin over the evaluation of a full set of 64 points plus any
   // stall on the result side.
   localparam int unsigned COORD_MAX   = (1 << COORD_BITS) - 1;
   localparam int unsigned QUIET_LIMIT = 40000;
   localparam int unsigned ITEM_TARGET = 1250;

   // One expected or observed result of a closed set.
   typedef struct packed {
      logic [COORD_BITS-1:0] value;
      logic [1:0]            which_ref;
      logic                  ok;
   } half_mean_type;

   // Tracks the samples of the open set, predicts the half mean when a set closes, and
   // compares each result that the block hands over with the oldest prediction.
   class half_mean_tracker_type;
      logic [COORD_BITS-1:0] held_x [MAX_POINTS];
      logic [COORD_BITS-1:0] held_y [MAX_POINTS];
      int unsigned           held_count;
      half_mean_type         pending_means [$];
      int unsigned           results_seen;
      int unsigned           errors;

      function new();
         held_count   = 0;
         results_seen = 0;
         errors       = 0;
      endfunction

      task report(string what);
         errors++;
         $display("mismatch at %0t: %s", $realtime, what);
      endtask

      // Stores the sample (unless the store is full) and, on the closing sample, sorts the
      // chosen coordinate and averages the selected half.
      function void note_sample(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                                logic [1:0] mode, logic last);
         int unsigned   sorted_keys [];
         int unsigned   lo;
         int unsigned   hi;
         int unsigned   total;
         half_mean_type expected;
         if (held_count < MAX_POINTS) begin
            held_x[held_count] = x;
            held_y[held_count] = y;
            held_count++;
         end
         if (!last) return;
         sorted_keys = new[held_count];
         for (int i = 0; i < held_count; i++) begin
            if (mode == MODE_TOP || mode == MODE_BOTTOM) sorted_keys[i] = held_y[i];
            else sorted_keys[i] = held_x[i];
         end
         sorted_keys.sort();
         // Left and bottom take the upper half, right and top the lower half.
         if (mode == MODE_LEFT || mode == MODE_BOTTOM) begin
            lo = held_count / 2;
            hi = held_count;
         end else begin
            lo = 0;
            hi = held_count / 2;
         end
         total = 0;
         for (int i = lo; i < hi; i++) total += sorted_keys[i];
         expected.which_ref = mode;
         if (hi == lo) begin
            expected.value = '0;
            expected.ok    = 1'b0;
         end else begin
            expected.value = COORD_BITS'(total / (hi - lo));
            expected.ok    = 1'b1;
         end
         pending_means = {pending_means, expected};
         held_count = 0;
      endfunction

      task check_mean(half_mean_type got);
         half_mean_type want;
         results_seen++;
         if (pending_means.size() == 0) begin
            report($sformatf("result %0d arrived with nothing expected", results_seen));
            return;
         end
         want = pending_means.pop_front();
         if (got.value !== want.value)
            report($sformatf("result %0d ref_value got %0d want %0d",
                             results_seen, got.value, want.value));
         if (got.which_ref !== want.which_ref)
            report($sformatf("result %0d which_ref got %0d want %0d",
                             results_seen, got.which_ref, want.which_ref));
         if (got.ok !== want.ok)
            report($sformatf("result %0d ok got %0b want %0b", results_seen, got.ok, want.ok));
      endtask

      function int unsigned outstanding();
         return pending_means.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_stall;
   logic [COORD_BITS-1:0] req_x_coord   = '0;
   logic [COORD_BITS-1:0] req_y_coord   = '0;
   logic [1:0]            req_mode      = MODE_LEFT;
   logic                  req_last      = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall     = 1'b0;
   logic [COORD_BITS-1:0] rsp_ref_value;
   logic [1:0]            rsp_which_ref;
   logic                  rsp_ok;

   half_mean_tracker_type tracker;
   int unsigned           items_sent  = 0;
   int unsigned           quiet_count = 0;

   // Both sides stop idling for a long stretch in the middle of the random part, so the block
   // also sees back-to-back items and results taken the moment they appear.
   wire steady = (items_sent >= 500) && (items_sent < 800);

   half_set_reference_mean_core u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_x_coord   (req_x_coord),
      .req_y_coord   (req_y_coord),
      .req_mode      (req_mode),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_ref_value (rsp_ref_value),
      .rsp_which_ref (rsp_which_ref),
      .rsp_ok        (rsp_ok)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The result side stalls at random about 18 percent of the time, except in reset and in the steady stretch.
   always @(posedge clock) begin
      rsp_stall <= !reset && !steady && ($urandom_range(0, 99) < 18);
   end

   // Every handshake is sampled here at the clock edge, so the values seen are the ones that
   // were stable before the edge. The quiet counter feeds the watchdog below.
   always @(posedge clock) begin
      if (reset) begin
         quiet_count <= 0;
      end else begin
         if (req_valid && !req_stall)
            tracker.note_sample(req_x_coord, req_y_coord, req_mode, req_last);
         if (rsp_valid && !rsp_stall)
            tracker.check_mean('{value: rsp_ref_value, which_ref: rsp_which_ref, ok: rsp_ok});
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_count <= 0;
         else quiet_count <= quiet_count + 1;
      end
   end

   // Ends the run when nothing has moved on either channel for far longer than the slowest
   // set could take.
   initial begin
      while (quiet_count < QUIET_LIMIT) @(posedge clock);
      $display("quiet for %0d cycles with %0d results outstanding",
               quiet_count, tracker.outstanding());
      $display("FAIL");
      $finish;
   end

   // Presents one sample and holds it until the block takes it. Before the item, the sender
   // may idle for a geometric number of cycles. Valid is raised or lowered only once per edge.
   task automatic send_item(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                            logic [1:0] mode, logic last);
      while (!steady && ($urandom_range(0, 99) < 18)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_x_coord <= x;
      req_y_coord <= y;
      req_mode    <= mode;
      req_last    <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // Drops valid and waits until every predicted result has been taken.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.outstanding() != 0) @(posedge clock);
   endtask

   // Coordinates lean toward the extremes and toward a narrow band, so sets often hold
   // equal keys and the sort order among them gets exercised.
   function automatic logic [COORD_BITS-1:0] pick_coord();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return COORD_BITS'(COORD_MAX);
         2:       return COORD_BITS'($urandom_range(2000, 2003));
         default: return COORD_BITS'($urandom_range(0, COORD_MAX));
      endcase
   endfunction

   // Sends a set of the given size. Only the closing item's mode matters; the others carry a
   // random mode so those bits move too. Sets longer than the store overflow it on purpose.
   task automatic send_set(int unsigned size, logic [1:0] mode);
      for (int unsigned i = 0; i < size; i++) begin
         if (i == size - 1) send_item(pick_coord(), pick_coord(), mode, 1'b1);
         else send_item(pick_coord(), pick_coord(), 2'($urandom_range(0, 3)), 1'b0);
      end
   endtask

   initial begin
      int unsigned set_count;
      int unsigned set_size;
      tracker = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Single-sample sets: left and bottom average one point, right and top find an empty
      // lower half and report a failure. Each uses a corner of the coordinate range.
      send_item(COORD_BITS'(COORD_MAX), '0, MODE_LEFT, 1'b1);
      send_item('0, COORD_BITS'(COORD_MAX), MODE_RIGHT, 1'b1);
      send_item(COORD_BITS'(COORD_MAX), COORD_BITS'(COORD_MAX), MODE_TOP, 1'b1);
      send_item('0, '0, MODE_BOTTOM, 1'b1);

      // Two opposite corners under every mode: each half holds exactly one extreme.
      send_item('0, COORD_BITS'(COORD_MAX), MODE_TOP, 1'b0);
      send_item(COORD_BITS'(COORD_MAX), '0, MODE_LEFT, 1'b1);
      send_item('0, COORD_BITS'(COORD_MAX), MODE_BOTTOM, 1'b0);
      send_item(COORD_BITS'(COORD_MAX), '0, MODE_RIGHT, 1'b1);
      send_item('0, COORD_BITS'(COORD_MAX), MODE_LEFT, 1'b0);
      send_item(COORD_BITS'(COORD_MAX), '0, MODE_TOP, 1'b1);
      send_item('0, COORD_BITS'(COORD_MAX), MODE_RIGHT, 1'b0);
      send_item(COORD_BITS'(COORD_MAX), '0, MODE_BOTTOM, 1'b1);

      // Equal x keys with distinct y.
      send_item(12'd2048, 12'd100, MODE_RIGHT, 1'b0);
      send_item(12'd2048, 12'd200, MODE_TOP, 1'b0);
      send_item(12'd2048, 12'd300, MODE_LEFT, 1'b1);

      // Odd set in descending order, so the lower half is smaller and the sort does work.
      send_item(12'd10, 12'd4000, MODE_LEFT, 1'b0);
      send_item(12'd20, 12'd3000, MODE_LEFT, 1'b0);
      send_item(12'd30, 12'd2000, MODE_LEFT, 1'b0);
      send_item(12'd40, 12'd1001, MODE_LEFT, 1'b0);
      send_item(12'd50, 12'd2, MODE_TOP, 1'b1);

      // Every key at the maximum: every term of the sum at its largest, and a mean that must come back unchanged.
      for (int i = 0; i < 4; i++)
         send_item(COORD_BITS'(COORD_MAX), COORD_BITS'(COORD_MAX), MODE_BOTTOM, i == 3);

      drain_results();

      // Random sets. Most are small; a forced exactly-full set, a forced overflowing set and
      // an occasional set near the store depth cover the full-store behavior.
      set_count = 0;
      while (items_sent < ITEM_TARGET) begin
         if (set_count == 5) set_size = MAX_POINTS + 3;
         else if (set_count == 30) set_size = MAX_POINTS;
         else if ($urandom_range(0, 49) == 0) set_size = $urandom_range(MAX_POINTS - 2,
                                                                          MAX_POINTS + 6);
         else set_size = $urandom_range(1, 12);
         send_set(set_size, 2'($urandom_range(0, 3)));
         set_count++;
         if (set_count == 100) drain_results();
      end

      // Wait for the last results, then give the block time to show any stray result.
      drain_results();
      repeat (200) @(posedge clock);

      if (tracker.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
